// ===== design/fcob_pkg.sv =====
// shared types, register indexes and the per-byte over blend function
// for the frame compositor; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fcob_pkg;

    localparam int PIX_W      = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 64;

    localparam int MODE_BASE_BIT  = 0;
    localparam int MODE_BLEND_BIT = 1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CANVAS_WIDTH  = 3'd0,
        REG_CANVAS_HEIGHT = 3'd1,
        REG_FG_LEFT       = 3'd2,
        REG_FG_TOP        = 3'd3,
        REG_FG_COLS       = 3'd4,
        REG_FG_ROWS       = 3'd5,
        REG_FILL_COLOR    = 3'd6,
        REG_MODE_BITS     = 3'd7
    } cfg_addr_t;

    typedef struct packed {
        logic [12:0]      width_px;
        logic [12:0]      height_px;
        logic [11:0]      fg_left;
        logic [11:0]      fg_top;
        logic [12:0]      fg_cols;
        logic [12:0]      fg_rows;
        logic [PIX_W-1:0] fill_color;
        logic [1:0]       mode_bits;
    } fcob_cfg_t;

    typedef struct packed {
        logic in_rect;
        logic frame_end;
    } fcob_pos_t;

    // b = f + round(b * inv_alpha / 255), wrapping to 8 bits
    function automatic logic [7:0] blend_byte(input logic [7:0] inv_alpha,
                                              input logic [7:0] base_b,
                                              input logic [7:0] top_b);
        logic [15:0] t;
        logic [15:0] s;
        t = {8'd0, inv_alpha} * {8'd0, base_b} + 16'h0080;
        s = t + {8'd0, t[15:8]};
        return top_b + s[15:8];
    endfunction

endpackage

`default_nettype wire

// ===== design/fcob_cfg_regs.sv =====
// configuration register file of the frame compositor
// depends on fcob_pkg
`timescale 1ns / 1ps
`default_nettype none

module fcob_cfg_regs
    import fcob_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    output fcob_cfg_t                  cfg
);

    fcob_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.width_px      <= 13'd1;
            cfg_reg.height_px     <= 13'd1;
            cfg_reg.fg_left       <= 12'd0;
            cfg_reg.fg_top        <= 12'd0;
            cfg_reg.fg_cols       <= 13'd0;
            cfg_reg.fg_rows       <= 13'd0;
            cfg_reg.fill_color    <= '0;
            cfg_reg.mode_bits     <= 2'd0;
        end else if (cfg_wr_en) begin
            case (cfg_addr_t'(cfg_addr))
                REG_CANVAS_WIDTH:  cfg_reg.width_px      <= cfg_wr_data[12:0];
                REG_CANVAS_HEIGHT: cfg_reg.height_px     <= cfg_wr_data[12:0];
                REG_FG_LEFT:       cfg_reg.fg_left       <= cfg_wr_data[11:0];
                REG_FG_TOP:        cfg_reg.fg_top        <= cfg_wr_data[11:0];
                REG_FG_COLS:       cfg_reg.fg_cols       <= cfg_wr_data[12:0];
                REG_FG_ROWS:       cfg_reg.fg_rows       <= cfg_wr_data[12:0];
                REG_FILL_COLOR:    cfg_reg.fill_color    <= cfg_wr_data[PIX_W-1:0];
                REG_MODE_BITS:     cfg_reg.mode_bits     <= cfg_wr_data[1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== design/fcob_position.sv =====
// raster position counters, rectangle hit test and end-of-frame flag
// depends on fcob_pkg
`timescale 1ns / 1ps
`default_nettype none

module fcob_position
    import fcob_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire fcob_cfg_t cfg,
    input  wire logic      advance,
    output fcob_pos_t      pos
);

    localparam int CW    = $clog2(MAX_DIM);
    localparam int CMP_W = ((CW > 13) ? CW : 13) + 1;
    localparam logic [CMP_W-1:0] MAX_DIM_C = CMP_W'(MAX_DIM);
    localparam logic [CMP_W-1:0] ONE_C     = CMP_W'(1);

    logic [CW-1:0]    col_reg, col_next;
    logic [CW-1:0]    row_reg, row_next;
    logic [CMP_W-1:0] w_raw, h_raw, w_eff, h_eff;
    logic [CMP_W-1:0] col_ext, row_ext, col_p1, row_p1;
    logic [CMP_W-1:0] left_ext, top_ext, right_ext, bottom_ext;
    logic             last_col, last_row;

    always_comb begin
        w_raw = CMP_W'(cfg.width_px);
        h_raw = CMP_W'(cfg.height_px);
        if (w_raw == '0) begin
            w_eff = ONE_C;
        end else if (w_raw > MAX_DIM_C) begin
            w_eff = MAX_DIM_C;
        end else begin
            w_eff = w_raw;
        end
        if (h_raw == '0) begin
            h_eff = ONE_C;
        end else if (h_raw > MAX_DIM_C) begin
            h_eff = MAX_DIM_C;
        end else begin
            h_eff = h_raw;
        end
    end

    always_comb begin
        col_ext    = CMP_W'(col_reg);
        row_ext    = CMP_W'(row_reg);
        col_p1     = col_ext + ONE_C;
        row_p1     = row_ext + ONE_C;
        left_ext   = CMP_W'(cfg.fg_left);
        top_ext    = CMP_W'(cfg.fg_top);
        right_ext  = left_ext + CMP_W'(cfg.fg_cols);
        bottom_ext = top_ext + CMP_W'(cfg.fg_rows);
        last_col   = (col_p1 >= w_eff);
        last_row   = (row_p1 >= h_eff);

        pos.in_rect   = (row_ext >= top_ext) && (row_ext < bottom_ext) &&
                        (col_ext >= left_ext) && (col_ext < right_ext);
        pos.frame_end = last_col && last_row;
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_p1[CW-1:0];
            end else begin
                col_next = col_p1[CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/fcob_blend.sv =====
// premultiplied alpha over blend of four bytes, combinational
// depends on fcob_pkg (blend_byte)
`timescale 1ns / 1ps
`default_nettype none

module fcob_blend
    import fcob_pkg::*;
#(
    parameter int ALPHA_BYTE = 3
) (
    input  wire logic [PIX_W-1:0] base_px,
    input  wire logic [PIX_W-1:0] top_px,
    output logic      [PIX_W-1:0] blend_px
);

    logic [7:0] inv_alpha;

    assign inv_alpha = 8'hFF - top_px[ALPHA_BYTE*8 +: 8];

    for (genvar k = 0; k < 4; k++) begin : g_byte
        assign blend_px[k*8 +: 8] = blend_byte(inv_alpha, base_px[k*8 +: 8],
                                               top_px[k*8 +: 8]);
    end

endmodule

`default_nettype wire

// ===== design/frame_compositor_over_blend.sv =====
// Frame compositor, top level: two-register pixel pipeline with config port
// Depends on fcob_pkg, fcob_cfg_regs, fcob_position, fcob_blend
//
// Usage:
//   s_axis carries one canvas position per transaction in raster order:
//   tdata[31:0] background pixel, tdata[63:32] foreground pixel.
//   m_axis returns the composited pixel in tdata[31:0]; tlast marks the
//   last pixel of the frame (end of the bottom row).
//   cfg_wr_en/cfg_addr/cfg_wr_data write one register per cycle; write
//   only while the pipeline is empty.
// Throughput: one pixel per clock while m_axis is not stalled; the input
//   transaction passes the input register, then the result register,
//   which drives m_axis.
//   The per-pixel blend is four 8x8 multiplies with adds between the
//   two registers.
// Reset: synchronous, active low; clears both pipeline valids, the
//   raster counters and the configuration registers to their defaults.
// Stall: when m_axis_tready is low the result register holds; the input
//   register still fills while it is empty, so at most one more transaction
//   is taken before s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module frame_compositor_over_blend
    import fcob_pkg::*;
#(
    parameter int MAX_DIM    = 4096,
    parameter int ALPHA_BYTE = 3
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // base_pixel, top_pixel
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic      [PIX_W-1:0]      m_axis_tdata,  // out_pixel
    output logic                       m_axis_tlast
);

    fcob_cfg_t  cfg;
    fcob_pos_t  pos;
    logic       s_accept;
    logic       a_ready, b_ready;
    logic [PIX_W-1:0] blend_px;

    logic             a_valid_reg;
    logic [PIX_W-1:0] a_base_reg;
    logic [PIX_W-1:0] a_top_reg;
    logic             a_inside_reg;
    logic             a_blend_reg;
    logic             a_last_reg;

    logic             b_valid_reg;
    logic [PIX_W-1:0] b_pixel_reg;
    logic             b_last_reg;

    fcob_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    fcob_position #(
        .MAX_DIM (MAX_DIM)
    ) u_pos (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .advance (s_accept),
        .pos     (pos)
    );

    fcob_blend #(
        .ALPHA_BYTE (ALPHA_BYTE)
    ) u_blend (
        .base_px  (a_base_reg),
        .top_px   (a_top_reg),
        .blend_px (blend_px)
    );

    assign b_ready       = !b_valid_reg || m_axis_tready;
    assign a_ready       = !a_valid_reg || b_ready;
    assign s_axis_tready = a_ready;
    assign s_accept      = s_axis_tvalid && a_ready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_base_reg   <= cfg.mode_bits[MODE_BASE_BIT] ? s_axis_tdata[PIX_W-1:0]
                                                         : cfg.fill_color;
            a_top_reg    <= s_axis_tdata[2*PIX_W-1:PIX_W];
            a_inside_reg <= pos.in_rect;
            a_blend_reg  <= cfg.mode_bits[MODE_BLEND_BIT];
            a_last_reg   <= pos.frame_end;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_ready && a_valid_reg) begin
            if (!a_inside_reg) begin
                b_pixel_reg <= a_base_reg;
            end else if (a_blend_reg) begin
                b_pixel_reg <= blend_px;
            end else begin
                b_pixel_reg <= a_top_reg;
            end
            b_last_reg <= a_last_reg;
        end
    end

    assign m_axis_tvalid = b_valid_reg;
    assign m_axis_tdata  = b_pixel_reg;
    assign m_axis_tlast  = b_last_reg;

endmodule

`default_nettype wire

// ===== design/fcob_checker.sv =====
// port-level checks for the frame compositor, bound to the top level
// depends on fcob_pkg and frame_compositor_over_blend
`timescale 1ns / 1ps
`default_nettype none

module fcob_checker
    import fcob_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_axis_tvalid,
    input wire logic                 s_axis_tready,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [PIX_W-1:0]     m_axis_tdata,
    input wire logic                 m_axis_tlast
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output changed");

    // nothing comes out right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
    else $error("output valid after reset");

    // empty output side means the input side is open
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked while output empty");

    // an accepted transaction shows up at the output after the input and result registers
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |-> ##2 m_axis_tvalid)
    else $error("accepted transaction not presented");

endmodule

bind frame_compositor_over_blend fcob_checker u_fcob_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
